>>> sv/mpfb_pkg.sv
// shared types and constants for the monochrome page frame buffer draw engine
package mpfb_pkg;

  // default geometry
  localparam int DEF_COLUMNS = 128;
  localparam int DEF_PAGES   = 8;

  // port field widths
  localparam int CMD_W  = 3;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int WID_W  = 8;
  localparam int HGT_W  = 7;
  localparam int BYTE_W = 8;

  // width of coordinate sums (col + width, row + height, up to 256 columns)
  localparam int SUM_W = 9;

  // drawing commands
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_HLINE  = 3'd1,
    CMD_VLINE  = 3'd2,
    CMD_FILL   = 3'd3,
    CMD_INVERT = 3'd4,
    CMD_ORBYTE = 3'd5,
    CMD_READ   = 3'd6
  } cmd_t;

  // per-byte modify operation
  typedef enum logic [1:0] {
    OP_CLR  = 2'd0,
    OP_SET  = 2'd1,
    OP_XOR  = 2'd2,
    OP_READ = 2'd3
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_INIT  = 3'd0,
    S_IDLE  = 3'd1,
    S_CLEAR = 3'd2,
    S_WALK  = 3'd3,
    S_DRAIN = 3'd4,
    S_DONE  = 3'd5
  } state_t;

endpackage

>>> sv/mono_page_framebuffer_draw_engine.sv
// Monochrome page frame buffer with a read-modify-write drawing sequencer.
// Input channel (in_*): one drawing command per transaction, accepted when
// in_valid is high and in_stall is low. Output channel (out_*): exactly one
// result transaction per command, read_data and clipped, held while out_stall.
// The frame store is PAGES*COLUMNS bytes in one synchronous memory (one write
// port, one read port, registered read data). A draw command walks every
// column byte of every page it touches: one byte per cycle, read issued one
// cycle and written back the next. Read byte walks a single byte, OR byte
// one or two, a command that touches nothing goes straight to its result,
// and clear writes a zero to every byte of the store, one per cycle.
// A new command is taken once the previous one has its result in the output
// register; a waiting result does not hold off the next command, but the
// block finishes only when the output register is free again.
// After reset the store is zeroed by a pass that writes every byte, during
// which in_stall is high; no result is produced for it.
module mono_page_framebuffer_draw_engine #(
  parameter int COLUMNS = mpfb_pkg::DEF_COLUMNS,
  parameter int PAGES   = mpfb_pkg::DEF_PAGES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mpfb_pkg::CMD_W-1:0]    in_cmd,
  input  logic [mpfb_pkg::COL_W-1:0]    in_col_x,
  input  logic [mpfb_pkg::ROW_W-1:0]    in_row_y,
  input  logic [mpfb_pkg::WID_W-1:0]    in_width_w,
  input  logic [mpfb_pkg::HGT_W-1:0]    in_height_h,
  input  logic                          in_pixel_val,
  input  logic [mpfb_pkg::BYTE_W-1:0]   in_pixel_bits,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mpfb_pkg::BYTE_W-1:0]   out_read_data,
  output logic                          out_clipped
);
  import mpfb_pkg::*;

  localparam int ROWS  = PAGES * 8;
  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COLUMNS);
  localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;

  // state and walk registers
  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_r;
  logic [CW-1:0]      col_r, col_lo_r, col_hi_r;
  logic [PGW-1:0]     page_r, page_lo_r, page_hi_r;
  logic [SUM_W-1:0]   y_r, yend_r;
  logic [15:0]        shift_r;
  logic               orb_r;
  op_t                op_r;
  logic               clip_r;
  logic [BYTE_W-1:0]  rd_data_r;

  // read-to-write pipeline stage
  logic               pend_r;
  logic [AW-1:0]      pend_addr_r;
  logic [BYTE_W-1:0]  pend_mask_r;

  // output register
  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_read_data_r;
  logic               out_clipped_r;

  // frame store
  logic [BYTE_W-1:0]  frame_mem [DEPTH];
  logic [BYTE_W-1:0]  mem_q_r;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [BYTE_W-1:0]  wr_data;

  // command decode
  cmd_t               cmd;
  logic               in_fire;
  logic [SUM_W-1:0]   w_e, h_e, x_ext, y_ext, xend, yend, xend_m1, yend_m1;
  logic               dec_empty, dec_clip;
  op_t                dec_op;

  // walk control
  logic               last_col, last_elem, clearing, out_load;
  logic [BYTE_W-1:0]  page_mask;

  assign cmd     = cmd_t'(in_cmd);
  assign in_fire = in_valid && !in_stall;

  // effective shape size, clip and bounds for the incoming command
  always_comb begin
    w_e    = SUM_W'(1);
    h_e    = SUM_W'(1);
    dec_op = in_pixel_val ? OP_SET : OP_CLR;
    case (cmd)
      CMD_HLINE: begin
        w_e = SUM_W'(in_width_w);
      end
      CMD_VLINE: begin
        h_e = SUM_W'(in_height_h);
      end
      CMD_FILL: begin
        w_e = SUM_W'(in_width_w);
        h_e = SUM_W'(in_height_h);
      end
      CMD_INVERT: begin
        w_e    = SUM_W'(in_width_w);
        h_e    = SUM_W'(in_height_h);
        dec_op = OP_XOR;
      end
      CMD_ORBYTE: begin
        h_e    = SUM_W'(8);
        dec_op = OP_SET;
      end
      CMD_READ: begin
        dec_op = OP_READ;
      end
      default: begin
        w_e = '0;
      end
    endcase
    x_ext = SUM_W'(in_col_x);
    y_ext = SUM_W'(in_row_y);
    xend  = x_ext + w_e;
    yend  = y_ext + h_e;
    dec_clip  = (w_e != '0) && (h_e != '0) &&
                ((xend > SUM_W'(COLUMNS)) || (yend > SUM_W'(ROWS)));
    dec_empty = (w_e == '0) || (h_e == '0) ||
                (x_ext >= SUM_W'(COLUMNS)) || (y_ext >= SUM_W'(ROWS));
    if (xend > SUM_W'(COLUMNS)) begin
      xend = SUM_W'(COLUMNS);
    end
    if (yend > SUM_W'(ROWS)) begin
      yend = SUM_W'(ROWS);
    end
    xend_m1 = xend - SUM_W'(1);
    yend_m1 = yend - SUM_W'(1);
  end

  // row mask of the page under the read pointer
  always_comb begin
    logic [SUM_W-1:0] row;
    page_mask = '0;
    for (int n = 0; n < 8; n++) begin
      row = SUM_W'(int'(page_r) * 8 + n);
      page_mask[n] = (row >= y_r) && (row < yend_r);
    end
    // or byte sets only the pixels whose bits are one
    if (orb_r) begin
      page_mask = (page_r == page_lo_r) ? shift_r[7:0] : shift_r[15:8];
    end
  end

  assign last_col  = (col_r == col_hi_r);
  assign last_elem = last_col && (page_r == page_hi_r);
  assign clearing  = (state_r == S_INIT) || (state_r == S_CLEAR);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (cmd == CMD_CLEAR)  state_nxt = S_CLEAR;
          else if (dec_empty)    state_nxt = S_DONE;
          else                   state_nxt = S_WALK;
        end
      end
      S_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) state_nxt = S_DONE;
      end
      S_WALK: begin
        if (last_elem) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // handshake and memory port controls
  always_comb begin
    in_stall = (state_r != S_IDLE);
    rd_en    = (state_r == S_WALK);
    rd_addr  = AW'(int'(page_r) * COLUMNS + int'(col_r));
    wr_en    = clearing || (pend_r && op_r != OP_READ);
    wr_addr  = clearing ? clr_r : pend_addr_r;
    case (op_r)
      OP_SET:  wr_data = mem_q_r | pend_mask_r;
      OP_CLR:  wr_data = mem_q_r & ~pend_mask_r;
      OP_XOR:  wr_data = mem_q_r ^ pend_mask_r;
      default: wr_data = mem_q_r;
    endcase
    if (clearing) begin
      wr_data = '0;
    end
  end

  // frame store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= frame_mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == S_WALK);
      if (clearing) begin
        clr_r <= (clr_r == AW'(DEPTH - 1)) ? '0 : clr_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      col_r     <= CW'(in_col_x);
      col_lo_r  <= CW'(in_col_x);
      col_hi_r  <= CW'(xend_m1);
      page_r    <= PGW'(in_row_y >> 3);
      page_lo_r <= PGW'(in_row_y >> 3);
      page_hi_r <= PGW'(yend_m1 >> 3);
      y_r       <= y_ext;
      yend_r    <= yend;
      shift_r   <= (cmd == CMD_ORBYTE) ? (16'(in_pixel_bits) << in_row_y[2:0]) : '0;
      orb_r     <= (cmd == CMD_ORBYTE);
      op_r      <= dec_op;
      clip_r    <= (cmd == CMD_CLEAR) ? 1'b0 : dec_clip;
      rd_data_r <= '0;
    end
    if (state_r == S_WALK) begin
      pend_addr_r <= rd_addr;
      pend_mask_r <= page_mask;
      if (last_col) begin
        col_r  <= col_lo_r;
        page_r <= page_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
    if (pend_r && op_r == OP_READ) begin
      rd_data_r <= mem_q_r;
    end
    if (out_load) begin
      out_read_data_r <= rd_data_r;
      out_clipped_r   <= clip_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_clipped   = out_clipped_r;

  // no pixel write outside a clear pass or a walk
  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r != S_IDLE && state_r != S_DONE))
    else $error("frame store written while sequencer idle");

  // a read command never writes the store back
  a_read_no_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && op_r == OP_READ) |-> !wr_en)
    else $error("read command wrote the frame store");

  // walk pointers stay inside the command bounds
  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (col_r <= col_hi_r && page_r <= page_hi_r))
    else $error("walk pointer past its bounds");

  // a new result only follows a finished command
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised without a finished command");

  // the last write-back is done before a new command can be taken
  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_r)
    else $error("write-back pending while idle");

endmodule
